// ----- rtl/core/fmba_pkg.sv -----
// Shared types and constants for the field magnitude background average block.
// Used by the square root unit, the top level and the checker.
// No dependencies.
package fmba_pkg;

    // Fixed widths of the sample fields and results.
    localparam int FIELD_W     = 16;
    localparam int MAG_W       = 16;
    localparam int RADICAND_W  = 32;
    localparam int COUNT_W     = 8;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // Register reset values.
    localparam logic [COUNT_W-1:0] STABLE_AFTER_RESET = 8'd36;
    localparam logic [MAG_W-1:0]   MAG_LIMIT_RESET    = 16'd32767;

    // The sample counter stops here.
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

    // Register indexes, taken from the word address.
    typedef enum logic {
        REG_STABLE_AFTER    = 1'b0,
        REG_MAGNITUDE_LIMIT = 1'b1
    } reg_index_t;

    // Sequencer states.
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SQUARE = 7'b0000010,
        ST_ROOT   = 7'b0000100,
        ST_UPDATE = 7'b0001000,
        ST_SCALE  = 7'b0010000,
        ST_ROUND  = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } state_t;

    // Result handed from the square root unit to the sequencer.
    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] root;
    } root_result_t;

endpackage

// ----- rtl/core/field_magnitude_background_average_top.sv -----
// Top level of the field magnitude background average block: sequencer, window
// arithmetic, APB registers and the output register.
// Depends on fmba_pkg, fmba_ram and fmba_sqrt.
//
//  Channel  | Direction | Handshake        | Beat contents
//  ---------+-----------+------------------+------------------------------------------
//  s_       | in        | s_valid/s_ready  | field_x, field_y, field_z, sensor_error
//  m_       | out       | m_valid/m_ready  | magnitude, average, average_valid, stable, fault
//  APB      | in/out    | psel/penable     | stable_after (0x0), magnitude_limit (0x4)
//
// The 16-step square root is the longest part of the work on one sample.
// One sample is worked at a time; a new input beat is taken while the last result
// still waits in the output register, and the sequencer holds before loading it.
// aresetn is synchronous and active low; the window RAM is not cleared, since an
// entry read back is used only after the window has been filled.
module field_magnitude_background_average_top #(
    parameter int WINDOW_LENGTH = 10
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Input sample channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [fmba_pkg::FIELD_W-1:0]  s_field_x,
    input  logic signed [fmba_pkg::FIELD_W-1:0]  s_field_y,
    input  logic signed [fmba_pkg::FIELD_W-1:0]  s_field_z,
    input  logic                                 s_sensor_error,
    // Result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [fmba_pkg::MAG_W-1:0]           m_magnitude,
    output logic [fmba_pkg::MAG_W-1:0]           m_average,
    output logic                                 m_average_valid,
    output logic                                 m_stable,
    output logic                                 m_fault,
    // Configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [fmba_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [fmba_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [fmba_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    localparam int MAG_W   = fmba_pkg::MAG_W;
    localparam int FIELD_W = fmba_pkg::FIELD_W;
    localparam int RAD_W   = fmba_pkg::RADICAND_W;
    localparam int COUNT_W = fmba_pkg::COUNT_W;
    localparam int DATA_W  = fmba_pkg::APB_DATA_W;
    localparam int SLOT_W  = $clog2(WINDOW_LENGTH);
    localparam int SUM_W   = MAG_W + $clog2(WINDOW_LENGTH);
    localparam int PROD_W  = 2 * SUM_W;

    // Reciprocal of the window length; the quotient estimate is low by at most one.
    localparam longint RECIP_L = (longint'(1) << SUM_W) / WINDOW_LENGTH;
    localparam logic [SUM_W-1:0]   RECIP     = SUM_W'(RECIP_L);
    localparam logic [SUM_W-1:0]   WL_SUM    = SUM_W'(WINDOW_LENGTH);
    localparam logic [COUNT_W-1:0] WL_COUNT  = COUNT_W'(WINDOW_LENGTH);
    localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(WINDOW_LENGTH - 1);

    fmba_pkg::state_t state_reg, state_next;

    logic [1:0]                 sq_idx_reg, sq_idx_next;
    logic signed [FIELD_W-1:0]  fx_reg, fy_reg, fz_reg;
    logic                       err_reg;
    logic [RAD_W-1:0]           acc_reg, acc_next;
    logic [MAG_W-1:0]           mag_reg, mag_next;
    logic                       take_reg, take_next;
    logic                       full_reg, full_next;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [SLOT_W-1:0]          slot_reg, slot_next;
    logic [COUNT_W-1:0]         count_reg, count_next;
    logic [MAG_W-1:0]           avg_reg, avg_next;
    logic                       avg_valid_reg, avg_valid_next;
    logic                       fault_reg, fault_next;
    logic [PROD_W-1:0]          prod_reg, prod_next;
    logic [COUNT_W-1:0]         stable_after_reg;
    logic [MAG_W-1:0]           limit_reg;

    logic                       out_valid_reg, out_valid_next;
    logic [MAG_W-1:0]           out_mag_reg, out_avg_reg;
    logic                       out_avg_valid_reg, out_stable_reg, out_fault_reg;
    logic                       out_load;

    logic                       in_beat;
    logic                       sqrt_start;
    fmba_pkg::root_result_t     root_res;
    logic                       ram_re, ram_we;
    logic [MAG_W-1:0]           old_mag;

    // Square and division helpers.
    logic signed [FIELD_W-1:0]  sq_sel;
    logic [FIELD_W-1:0]         sq_abs;
    logic [RAD_W-1:0]           sq_val;
    logic [MAG_W-1:0]           root_mag;
    logic [SUM_W-1:0]           quot_est, quot_back, quot_rem, quot_fix;

    assign s_ready = (state_reg == fmba_pkg::ST_IDLE);
    assign in_beat = s_valid && s_ready;

    // Window store: read the slot about to be replaced, write the new magnitude.
    fmba_ram #(
        .WIDTH (MAG_W),
        .DEPTH (WINDOW_LENGTH)
    ) u_window_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (mag_reg),
        .re    (ram_re),
        .raddr (slot_reg),
        .rdata (old_mag)
    );

    // Square root unit for the magnitude.
    fmba_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (acc_reg),
        .result   (root_res)
    );

    // One squarer, stepped over the three axes.
    always_comb begin
        case (sq_idx_reg)
            2'd0:    sq_sel = fx_reg;
            2'd1:    sq_sel = fy_reg;
            default: sq_sel = fz_reg;
        endcase
        sq_abs = sq_sel[FIELD_W-1] ? (~sq_sel + FIELD_W'(1)) : sq_sel;
        sq_val = RAD_W'(sq_abs) * RAD_W'(sq_abs);
    end

    // Magnitude is forced to zero on a sensor error.
    assign root_mag = err_reg ? '0 : root_res.root;

    // Quotient estimate, back-multiplied and corrected by one compare.
    always_comb begin
        quot_est  = prod_reg[PROD_W-1:SUM_W];
        quot_back = SUM_W'(quot_est * WL_SUM);
        quot_rem  = sum_reg - quot_back;
        quot_fix  = (quot_rem >= WL_SUM) ? quot_est + SUM_W'(1) : quot_est;
    end

    // Sequencer and window bookkeeping.
    always_comb begin
        state_next     = state_reg;
        sq_idx_next    = sq_idx_reg;
        acc_next       = acc_reg;
        mag_next       = mag_reg;
        take_next      = take_reg;
        full_next      = full_reg;
        sum_next       = sum_reg;
        slot_next      = slot_reg;
        count_next     = count_reg;
        avg_next       = avg_reg;
        avg_valid_next = avg_valid_reg;
        fault_next     = fault_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_load       = 1'b0;
        sqrt_start     = 1'b0;
        ram_re         = 1'b0;
        ram_we         = 1'b0;

        case (state_reg)
            fmba_pkg::ST_IDLE: begin
                if (in_beat) begin
                    ram_re      = 1'b1;
                    acc_next    = '0;
                    sq_idx_next = 2'd0;
                    state_next  = fmba_pkg::ST_SQUARE;
                end
            end
            fmba_pkg::ST_SQUARE: begin
                if (sq_idx_reg == 2'd3) begin
                    sqrt_start = 1'b1;
                    state_next = fmba_pkg::ST_ROOT;
                end else begin
                    acc_next    = acc_reg + sq_val;
                    sq_idx_next = sq_idx_reg + 2'd1;
                end
            end
            fmba_pkg::ST_ROOT: begin
                if (root_res.done) begin
                    mag_next   = root_mag;
                    take_next  = !fault_reg && !err_reg && (root_mag < limit_reg);
                    full_next  = (count_reg >= WL_COUNT);
                    fault_next = fault_reg || err_reg || (root_mag >= limit_reg);
                    state_next = fmba_pkg::ST_UPDATE;
                end
            end
            fmba_pkg::ST_UPDATE: begin
                if (take_reg) begin
                    ram_we    = 1'b1;
                    sum_next  = sum_reg + SUM_W'(mag_reg)
                              - (full_reg ? SUM_W'(old_mag) : '0);
                    slot_next = (slot_reg == LAST_SLOT) ? '0 : slot_reg + SLOT_W'(1);
                    if (count_reg != fmba_pkg::COUNT_MAX) begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
                state_next = fmba_pkg::ST_SCALE;
            end
            fmba_pkg::ST_SCALE: begin
                prod_next  = PROD_W'(sum_reg) * PROD_W'(RECIP);
                state_next = fmba_pkg::ST_ROUND;
            end
            fmba_pkg::ST_ROUND: begin
                if (take_reg && full_reg) begin
                    avg_next       = quot_fix[MAG_W-1:0];
                    avg_valid_next = 1'b1;
                end
                state_next = fmba_pkg::ST_EMIT;
            end
            fmba_pkg::ST_EMIT: begin
                // Load only once the previous result has left.
                if (!out_valid_reg || m_ready) begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = fmba_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fmba_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and architectural state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= fmba_pkg::ST_IDLE;
            sq_idx_reg    <= '0;
            sum_reg       <= '0;
            slot_reg      <= '0;
            count_reg     <= '0;
            avg_reg       <= '0;
            avg_valid_reg <= 1'b0;
            fault_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            take_reg      <= 1'b0;
            full_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sq_idx_reg    <= sq_idx_next;
            sum_reg       <= sum_next;
            slot_reg      <= slot_next;
            count_reg     <= count_next;
            avg_reg       <= avg_next;
            avg_valid_reg <= avg_valid_next;
            fault_reg     <= fault_next;
            out_valid_reg <= out_valid_next;
            take_reg      <= take_next;
            full_reg      <= full_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            fx_reg  <= s_field_x;
            fy_reg  <= s_field_y;
            fz_reg  <= s_field_z;
            err_reg <= s_sensor_error;
        end
        acc_reg  <= acc_next;
        mag_reg  <= mag_next;
        prod_reg <= prod_next;
        if (out_load) begin
            out_mag_reg       <= mag_reg;
            out_avg_reg       <= avg_reg;
            out_avg_valid_reg <= avg_valid_reg;
            out_stable_reg    <= (count_reg > stable_after_reg);
            out_fault_reg     <= fault_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_magnitude     = out_mag_reg;
    assign m_average       = out_avg_reg;
    assign m_average_valid = out_avg_valid_reg;
    assign m_stable        = out_stable_reg;
    assign m_fault         = out_fault_reg;

    // Configuration registers, written in the APB access phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_after_reg <= fmba_pkg::STABLE_AFTER_RESET;
            limit_reg        <= fmba_pkg::MAG_LIMIT_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (fmba_pkg::reg_index_t'(paddr[2]))
                fmba_pkg::REG_STABLE_AFTER:    stable_after_reg <= pwdata[COUNT_W-1:0];
                fmba_pkg::REG_MAGNITUDE_LIMIT: limit_reg        <= pwdata[MAG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (fmba_pkg::reg_index_t'(paddr[2]))
            fmba_pkg::REG_STABLE_AFTER:    prdata = DATA_W'(stable_after_reg);
            fmba_pkg::REG_MAGNITUDE_LIMIT: prdata = DATA_W'(limit_reg);
            default:                       prdata = '0;
        endcase
    end

    assign pready = 1'b1;

endmodule

// ----- rtl/core/fmba_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package dependency.
module fmba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 10
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/fmba_sqrt.sv -----
// Iterative floor square root of a 32-bit value, one result bit per cycle.
// Depends on fmba_pkg for widths and the result struct.
module fmba_sqrt (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [fmba_pkg::RADICAND_W-1:0]     radicand,
    output fmba_pkg::root_result_t              result
);

    localparam int W = fmba_pkg::RADICAND_W;

    logic [W-1:0] rem_reg;
    logic [W-1:0] root_reg;
    logic [W-1:0] bit_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [W-1:0] trial;
    logic         fits;

    // One trial subtraction per step.
    always_comb begin
        trial = root_reg + bit_reg;
        fits  = (rem_reg >= trial);
    end

    // Control: busy for sixteen steps, then a one-cycle done pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && bit_reg[0]) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath: the probe bit walks down two places per step.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= radicand;
            root_reg <= '0;
            bit_reg  <= W'(1) << (W - 2);
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg  <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end else begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign result.done = done_reg;
    assign result.root = root_reg[fmba_pkg::MAG_W-1:0];

endmodule

// ----- rtl/core/fmba_checker.sv -----
// Port-level checker for the field magnitude background average block,
// attached to the top level by the bind statement at the end of this file.
// Depends only on fmba_pkg for widths.
module fmba_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [fmba_pkg::MAG_W-1:0]   m_magnitude,
    input logic [fmba_pkg::MAG_W-1:0]   m_average,
    input logic                         m_average_valid,
    input logic                         m_fault
);

    logic fault_seen_reg;
    logic avg_valid_seen_reg;

    // Remember what earlier result beats have shown.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fault_seen_reg     <= 1'b0;
            avg_valid_seen_reg <= 1'b0;
        end else if (m_valid && m_ready) begin
            if (m_fault) begin
                fault_seen_reg <= 1'b1;
            end
            if (m_average_valid) begin
                avg_valid_seen_reg <= 1'b1;
            end
        end
    end

    // The fault stays set until reset.
    a_fault_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && fault_seen_reg |-> m_fault)
        else $error("fault cleared after it was reported");

    // Once an average has been given, every later beat carries one.
    a_avg_valid_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && avg_valid_seen_reg |-> m_average_valid)
        else $error("average_valid dropped after the window filled");

    // The average reads zero until the window has filled.
    a_avg_zero_early: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_average_valid |-> (m_average == '0))
        else $error("nonzero average before the window filled");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_magnitude) && $stable(m_average))
        else $error("result beat changed while stalled");

endmodule

bind field_magnitude_background_average_top fmba_checker u_fmba_checker (.*);

// ----- tb/field_magnitude_background_average_top_tb.sv -----
// Self-checking testbench for field_magnitude_background_average_top.
// Drives magnetometer samples and checks every result against a local predictor or a hand-written expectation.
// Depends on fmba_pkg and the block's RTL only.
`timescale 1ns / 1ps

module field_magnitude_background_average_top_tb;

    localparam int MAG_W      = fmba_pkg::MAG_W;
    localparam int FIELD_W    = fmba_pkg::FIELD_W;
    localparam int COUNT_W    = fmba_pkg::COUNT_W;
    localparam int APB_ADDR_W = fmba_pkg::APB_ADDR_W;
    localparam int APB_DATA_W = fmba_pkg::APB_DATA_W;

    localparam logic [COUNT_W-1:0] STABLE_AFTER_RESET = fmba_pkg::STABLE_AFTER_RESET;
    localparam logic [MAG_W-1:0]   MAG_LIMIT_RESET    = fmba_pkg::MAG_LIMIT_RESET;

    localparam int WINDOW         = 10;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 40;
    localparam int OPENING_ROWS   = 16;
    localparam int ALL_ROWS       = 20;

    // One result beat as seen on the m_ channel.
    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic [MAG_W-1:0] average;
        logic             average_valid;
        logic             stable;
        logic             fault;
    } field_report_t;

    // A directed sample, optionally with its result written out by hand.
    typedef struct packed {
        logic signed [FIELD_W-1:0] x;
        logic signed [FIELD_W-1:0] y;
        logic signed [FIELD_W-1:0] z;
        logic                      err;
        logic                      typed;
        field_report_t             report;
    } sample_row_t;

    // Hand-written expectation traveling with a beat from the sender to the monitor.
    typedef struct packed {
        logic          typed;
        field_report_t report;
    } row_note_t;

    localparam field_report_t NO_REPORT = '0;

    // The first ten rows are typed out by hand: window not full, count below 36.
    // The last rows fill the window, so the predictor takes over; the final four
    // run with a limit of zero and end in the sticky fault.
    sample_row_t sample_rows [ALL_ROWS] = '{
        '{16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1, '{16'd0, 16'd0, 1'b0, 1'b0, 1'b0}},
        '{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 1'b1,
          '{16'd56755, 16'd0, 1'b0, 1'b0, 1'b0}},
        '{16'sd32767, 16'sd32767, 16'sd32767, 1'b0, 1'b1,
          '{16'd56754, 16'd0, 1'b0, 1'b0, 1'b0}},
        '{16'sh8000, 16'sd0, 16'sd0, 1'b0, 1'b1, '{16'd32768, 16'd0, 1'b0, 1'b0, 1'b0}},
        '{16'sd0, 16'sd32767, 16'sd0, 1'b0, 1'b1, '{16'd32767, 16'd0, 1'b0, 1'b0, 1'b0}},
        '{16'sd0, 16'sd0, -16'sd1, 1'b0, 1'b1, '{16'd1, 16'd0, 1'b0, 1'b0, 1'b0}},
        '{16'sd3, -16'sd4, 16'sd0, 1'b0, 1'b1, '{16'd5, 16'd0, 1'b0, 1'b0, 1'b0}},
        '{-16'sd2, 16'sd3, 16'sd6, 1'b0, 1'b1, '{16'd7, 16'd0, 1'b0, 1'b0, 1'b0}},
        '{16'sd1, 16'sd1, 16'sd1, 1'b0, 1'b1, '{16'd1, 16'd0, 1'b0, 1'b0, 1'b0}},
        '{16'sd32767, 16'sh8000, 16'sd0, 1'b0, 1'b1,
          '{16'd46340, 16'd0, 1'b0, 1'b0, 1'b0}},
        '{16'sh5555, 16'shAAAA, 16'sh5555, 1'b0, 1'b0, NO_REPORT},
        '{16'shAAAA, 16'sh5555, 16'shAAAA, 1'b0, 1'b0, NO_REPORT},
        '{16'sd1, 16'sd0, 16'sd0, 1'b0, 1'b0, NO_REPORT},
        '{16'sd100, -16'sd200, 16'sd300, 1'b0, 1'b0, NO_REPORT},
        '{16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, NO_REPORT},
        '{16'sh8000, 16'sd32767, -16'sd1, 1'b0, 1'b0, NO_REPORT},
        // Limit of zero: even a zero magnitude faults.
        '{16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, NO_REPORT},
        // Already faulted: a sensor error still reports a zero magnitude.
        '{16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 1'b0, NO_REPORT},
        // Already faulted: the computed magnitude is still reported.
        '{16'sd100, 16'sd200, 16'sd300, 1'b0, 1'b0, NO_REPORT},
        '{16'sd32767, 16'sd0, 16'sd0, 1'b1, 1'b0, NO_REPORT}
    };

    logic                      aclk           = 1'b0;
    logic                      aresetn        = 1'b0;
    logic                      s_valid        = 1'b0;
    logic                      s_ready;
    logic signed [FIELD_W-1:0] s_field_x      = '0;
    logic signed [FIELD_W-1:0] s_field_y      = '0;
    logic signed [FIELD_W-1:0] s_field_z      = '0;
    logic                      s_sensor_error = 1'b0;
    logic                      m_valid;
    logic                      m_ready        = 1'b0;
    logic [MAG_W-1:0]          m_magnitude;
    logic [MAG_W-1:0]          m_average;
    logic                      m_average_valid;
    logic                      m_stable;
    logic                      m_fault;
    logic                      psel           = 1'b0;
    logic                      penable        = 1'b0;
    logic                      pwrite         = 1'b0;
    logic [APB_ADDR_W-1:0]     paddr          = '0;
    logic [APB_DATA_W-1:0]     pwdata         = '0;
    logic [APB_DATA_W-1:0]     prdata;
    logic                      pready;

    // Register copies seen by the predictor.
    logic [COUNT_W-1:0] stable_after_cfg = STABLE_AFTER_RESET;
    logic [MAG_W-1:0]   limit_cfg        = MAG_LIMIT_RESET;

    // Predictor state.
    logic [MAG_W-1:0] window_mags [WINDOW];
    int unsigned      window_total   = 0;
    int               next_slot      = 0;
    int               samples_seen   = 0;
    logic [MAG_W-1:0] held_average   = '0;
    logic             average_ready  = 1'b0;
    logic             latched_fault  = 1'b0;

    field_report_t pending_reports [$];
    row_note_t     row_notes [$];
    int            mismatch_count  = 0;
    int            result_count    = 0;
    int            sender_idle_pct = 0;
    int            stall_pct       = 0;
    int            hold_asks       = 0;
    int            hold_seen       = 0;
    int            hold_left       = 0;

    field_magnitude_background_average_top #(
        .WINDOW_LENGTH(WINDOW)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_field_x      (s_field_x),
        .s_field_y      (s_field_y),
        .s_field_z      (s_field_z),
        .s_sensor_error (s_sensor_error),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_magnitude    (m_magnitude),
        .m_average      (m_average),
        .m_average_valid(m_average_valid),
        .m_stable       (m_stable),
        .m_fault        (m_fault),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [31:0] axis_square(input logic signed [FIELD_W-1:0] v);
        int          s;
        logic [31:0] m;
        s = v;
        m = (s < 0) ? -s : s;
        return m * m;
    endfunction

    // Floor square root of x^2 + y^2 + z^2, built one result bit at a time.
    // The largest root is 56755, so the result always fits in 16 bits.
    function automatic logic [MAG_W-1:0] field_magnitude(
        input logic signed [FIELD_W-1:0] x, y, z);
        logic [31:0]      energy;
        logic [MAG_W-1:0] root;
        logic [MAG_W-1:0] trial;
        energy = axis_square(x) + axis_square(y) + axis_square(z);
        root = '0;
        for (int b = MAG_W - 1; b >= 0; b--) begin
            trial = root | (16'd1 << b);
            if ({16'd0, trial} * {16'd0, trial} <= energy)
                root = trial;
        end
        return root;
    endfunction

    // Advance the background tracker by one sample and return the result it reports.
    function automatic field_report_t track_sample(
        input logic signed [FIELD_W-1:0] x, y, z, input logic err);
        field_report_t r;
        logic [MAG_W-1:0] mag;
        mag = err ? '0 : field_magnitude(x, y, z);
        if (!latched_fault) begin
            if (err || mag >= limit_cfg) begin
                latched_fault = 1'b1;
            end else begin
                window_total += mag;
                if (samples_seen >= WINDOW) begin
                    window_total -= window_mags[next_slot];
                    held_average  = MAG_W'(window_total / WINDOW);
                    average_ready = 1'b1;
                end
                window_mags[next_slot] = mag;
                next_slot = (next_slot + 1) % WINDOW;
                if (samples_seen < 255)
                    samples_seen++;
            end
        end
        r.magnitude     = mag;
        r.average       = held_average;
        r.average_valid = average_ready;
        r.stable        = (samples_seen > stable_after_cfg);
        r.fault         = latched_fault;
        return r;
    endfunction

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("MISMATCH: %s", msg);
    endtask

    // One APB transfer: setup, access, then a return to idle. Writes update the
    // predictor's register copy at the edge that commits them.
    task automatic apb_access(input logic is_write, input fmba_pkg::reg_index_t idx,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        if (is_write) begin
            case (idx)
                fmba_pkg::REG_STABLE_AFTER:    stable_after_cfg = wdata[COUNT_W-1:0];
                fmba_pkg::REG_MAGNITUDE_LIMIT: limit_cfg        = wdata[MAG_W-1:0];
                default: ;
            endcase
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_register(input fmba_pkg::reg_index_t idx,
                                  input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] unused;
        apb_access(1'b1, idx, value, unused);
    endtask

    // Offer one sample beat after a random idle gap and hold it until accepted.
    task automatic offer_sample(input logic signed [FIELD_W-1:0] x, y, z,
                                input logic err, input logic typed,
                                input field_report_t report);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        row_notes.push_back('{typed, report});
        s_valid        <= 1'b1;
        s_field_x      <= x;
        s_field_y      <= y;
        s_field_z      <= z;
        s_sensor_error <= err;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_reports.size() != 0)
            @(posedge aclk);
    endtask

    task automatic walk_rows(input int first, input int last);
        for (int i = first; i <= last; i++)
            offer_sample(sample_rows[i].x, sample_rows[i].y, sample_rows[i].z,
                         sample_rows[i].err, sample_rows[i].typed, sample_rows[i].report);
    endtask

    // Random sample: mostly full-scale, a quarter near zero, halved until it
    // stays under the limit. Sensor errors are left out here since the fault
    // they raise would freeze the tracker for the rest of the run.
    task automatic pick_sample(output logic signed [FIELD_W-1:0] x, y, z);
        if ($urandom_range(3) == 0) begin
            x = 16'($urandom_range(510)) - 16'd255;
            y = 16'($urandom_range(510)) - 16'd255;
            z = 16'($urandom_range(510)) - 16'd255;
        end else begin
            x = 16'($urandom);
            y = 16'($urandom);
            z = 16'($urandom);
        end
        while (field_magnitude(x, y, z) >= limit_cfg) begin
            x = x / 16'sd2;
            y = y / 16'sd2;
            z = z / 16'sd2;
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_level,
                             input logic [COUNT_W-1:0] stable_val,
                             input logic [MAG_W-1:0] limit_val,
                             input int items, input logic long_hold);
        logic signed [FIELD_W-1:0] x, y, z;
        drain_results();
        write_register(fmba_pkg::REG_STABLE_AFTER, APB_DATA_W'(stable_val));
        write_register(fmba_pkg::REG_MAGNITUDE_LIMIT, APB_DATA_W'(limit_val));
        sender_idle_pct = idle_pct;
        stall_pct       = stall_level;
        if (long_hold)
            hold_asks++;
        repeat (items) begin
            pick_sample(x, y, z);
            offer_sample(x, y, z, 1'b0, 1'b0, NO_REPORT);
        end
    endtask

    // Result receiver: random stalls, plus a long hold-off on request.
    always @(posedge aclk) begin
        if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Beat monitor: check results first, then predict for the accepted sample.
    always @(posedge aclk) begin
        field_report_t got;
        field_report_t want;
        row_note_t     note;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = '{m_magnitude, m_average, m_average_valid, m_stable, m_fault};
                result_count++;
                if (pending_reports.size() == 0) begin
                    log_mismatch($sformatf("result %0d arrived with nothing expected",
                                           result_count));
                end else begin
                    want = pending_reports.pop_front();
                    if (got !== want)
                        log_mismatch($sformatf({"result %0d exp/act: magnitude %0d/%0d ",
                            "average %0d/%0d valid %b/%b stable %b/%b fault %b/%b"},
                            result_count, want.magnitude, got.magnitude,
                            want.average, got.average, want.average_valid,
                            got.average_valid, want.stable, got.stable,
                            want.fault, got.fault));
                end
            end
            if (s_valid && s_ready) begin
                note = row_notes.pop_front();
                want = track_sample(s_field_x, s_field_y, s_field_z, s_sensor_error);
                pending_reports.push_back(note.typed ? note.report : want);
            end
        end
    end

    // Watchdog: ends the run when no beat moves on either channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, pending_reports.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // Main sequence.
    initial begin
        logic [APB_DATA_W-1:0] readback;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Registers come out of reset at their documented values.
        apb_access(1'b0, fmba_pkg::REG_STABLE_AFTER, '0, readback);
        if (readback !== APB_DATA_W'(STABLE_AFTER_RESET))
            log_mismatch($sformatf("stable_after reads %0d after reset", readback));
        apb_access(1'b0, fmba_pkg::REG_MAGNITUDE_LIMIT, '0, readback);
        if (readback !== APB_DATA_W'(MAG_LIMIT_RESET))
            log_mismatch($sformatf("magnitude_limit reads %0d after reset", readback));

        // Directed samples with the widest limit so full-scale vectors pass.
        write_register(fmba_pkg::REG_MAGNITUDE_LIMIT, APB_DATA_W'(16'hFFFF));
        walk_rows(0, OPENING_ROWS - 1);

        // Random phases across idle patterns and register settings. The first
        // one opens with a long receiver hold-off while samples keep coming.
        run_phase(0, 0, 8'($urandom_range(200, 40)), 16'hFFFF, 260, 1'b1);
        run_phase(51, 0, 8'd254, 16'd1, 30, 1'b0);
        run_phase(51, 0, 8'd0, 16'hFFFF, 220, 1'b0);
        run_phase(0, 51, 8'($urandom_range(254)), MAG_LIMIT_RESET, 220, 1'b0);
        run_phase(17, 17, STABLE_AFTER_RESET, 16'($urandom_range(65535, 1)), 220, 1'b0);

        // Fault handling last, since only reset would clear it.
        drain_results();
        write_register(fmba_pkg::REG_MAGNITUDE_LIMIT, '0);
        walk_rows(OPENING_ROWS, ALL_ROWS - 1);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/fmba_pkg.sv
rtl/core/fmba_ram.sv
rtl/core/fmba_sqrt.sv
rtl/core/field_magnitude_background_average_top.sv
rtl/core/fmba_checker.sv
tb/field_magnitude_background_average_top_tb.sv
